// ===== src/rti_pkg.sv =====
`timescale 1ns / 1ps

package rti_pkg;

  // field and bus widths
  localparam int COORD_W = 32;
  localparam int IN_W    = 288;
  localparam int OUT_W   = 168;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int NCFG    = 6;

  // configuration register indexes
  localparam int CFG_OX = 0;
  localparam int CFG_OY = 1;
  localparam int CFG_OZ = 2;
  localparam int CFG_DX = 3;
  localparam int CFG_DY = 4;
  localparam int CFG_DZ = 5;

  // internal widths
  localparam int CW   = 33;   // vertex difference
  localparam int PW   = 66;   // product of two differences
  localparam int MW   = 67;   // 2x2 minor
  localparam int DW   = 100;  // determinant and numerators
  localparam int NW   = 134;  // hit point numerator
  localparam int LIMB = 34;   // limb of a split wide operand
  localparam int PPW  = 68;   // partial product
  localparam int QB   = 32;   // quotient bits of each divider

  localparam int BARY_BITS = 16;
  localparam logic [16:0] BARY_ONE = 17'h10000;
  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] PT_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] PT_MIN   = 32'h8000_0000;

  // left-hand operand codes of the 3x3 expansion
  localparam int X_E1 = 0;
  localparam int X_E2 = 1;
  localparam int X_S  = 2;
  localparam int X_ND = 3;

  // minor codes
  localparam int M_A  = 0;
  localparam int M_B  = 1;
  localparam int M_C  = 2;
  localparam int M_K1 = 3;
  localparam int M_K2 = 4;
  localparam int M_K3 = 5;
  localparam int NMINOR = 6;

  // rows of the expansion: determinant, beta, gamma and t numerators
  localparam int R_DET = 0;
  localparam int R_NB  = 1;
  localparam int R_NG  = 2;
  localparam int R_NT  = 3;

  localparam int TERM_X [4][3] = '{
    '{X_E1, X_E2, X_ND},
    '{X_S,  X_E2, X_ND},
    '{X_E1, X_S,  X_ND},
    '{X_E1, X_E2, X_S }
  };
  localparam int TERM_M [4][3] = '{
    '{M_A,  M_B,  M_C },
    '{M_A,  M_K1, M_K2},
    '{M_K1, M_B,  M_K3},
    '{M_K2, M_K3, M_C }
  };
  localparam bit TERM_NEG [4][3] = '{
    '{1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b0}
  };

  typedef struct packed {
    logic [2:0][CW-1:0]      e1;
    logic [2:0][CW-1:0]      e2;
    logic [2:0][CW-1:0]      s;
    logic [2:0][CW-1:0]      nd;
    logic [2:0][COORD_W-1:0] p0;
  } rti_geo_t;

  typedef struct packed {
    logic       v;
    logic       hit;
    logic [2:0] neg;
  } rti_side_t;

endpackage

// ===== src/rti_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
module rti_div #(
  parameter int NUM_W = 116,
  parameter int DEN_W = 99,
  parameter int QB    = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QB-1:0]    quo,
  output logic             sat
);

  localparam int RW = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

  logic [RW-1:0]    rem_r [QB];
  logic [DEN_W-1:0] den_r [QB];
  logic [QB-1:0]    q_r   [QB+1];
  logic             sat_r [QB+1];

  // flag a quotient that does not fit in QB bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      sat_r[0] <= ((RW'(num) >> QB) >= RW'(den));
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = RW'(den_r[k]) << SH;
    assign take  = (rem_r[k] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k+1]   <= {q_r[k][QB-2:0], take};
        sat_r[k+1] <= sat_r[k];
      end
    end

    if (k < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= take ? (rem_r[k] - trial) : rem_r[k];
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign quo = q_r[QB];
  assign sat = sat_r[QB];

endmodule

// ===== src/ray_triangle_intersection.sv =====
`timescale 1ns / 1ps

// Ray / triangle intersection test, fixed point with FRAC_BITS fraction bits.
// The ray (origin, direction) sits in six APB registers at byte addresses
// 0x00..0x14; write them only while no request is in flight.
// Input stream: one request per triangle, in_tdata = v0, v1, v2 as x, y, z
// words, 32 bits each, lowest word first.
// Output stream: one result per request, in request order. out_tuser is the
// hit flag; out_tdata holds distance, point and barycentric weights. A miss
// (including a degenerate triangle) returns all fields zero.
// Throughput: one request per cycle while the skid register is empty. The
// pipeline holds eleven arithmetic stages (differences, minors, split wide
// products, sums, sign normalisation, numerators, floor fix-up), then 33
// stages of the restoring dividers (a load stage, then one quotient bit per
// stage), then the output register. The divider depth sets the latency.
// Reset (synchronous, rst_n low) drops everything in flight and restores
// the ray to origin zero, direction +z.
// When the receiver stalls, the pending result holds on out_tdata and a skid
// register takes one more; in_tready falls only while the skid is full.
module ray_triangle_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic [rti_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // distance[30:0], point_x, point_y, point_z, bary_beta, bary_gamma, zero pad
  output logic [rti_pkg::OUT_W-1:0] out_tdata,
  // hit
  output logic [0:0]                out_tuser,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [rti_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [rti_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [rti_pkg::DATA_W-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  localparam int CW   = rti_pkg::CW;
  localparam int PW   = rti_pkg::PW;
  localparam int MW   = rti_pkg::MW;
  localparam int DW   = rti_pkg::DW;
  localparam int NW   = rti_pkg::NW;
  localparam int LIMB = rti_pkg::LIMB;
  localparam int PPW  = rti_pkg::PPW;
  localparam int QB   = rti_pkg::QB;
  localparam int DIST_NW = DW - 1 + FRAC_BITS;
  localparam int BARY_NW = DW - 1 + rti_pkg::BARY_BITS;

  // ---------------------------------------------------------------- config
  logic [31:0] cfg_r [rti_pkg::NCFG];
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rti_pkg::NCFG; i++) cfg_r[i] <= '0;
      cfg_r[rti_pkg::CFG_DZ] <= 32'(1) << FRAC_BITS;
    end else if (cfg_wr && (cfg_idx < 3'(rti_pkg::NCFG))) begin
      cfg_r[cfg_idx] <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_idx < 3'(rti_pkg::NCFG)) ? cfg_r[cfg_idx] : '0;

  // --------------------------------------------------------- flow control
  logic en;
  logic skid_v_r;
  logic out_v_r;
  logic [10:0] vld_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[9:0], in_tvalid};
    end
  end

  // ---------------------------------------------------- S1: differences
  rti_pkg::rti_geo_t geo_r [7];
  rti_pkg::rti_geo_t geo_in;

  always_comb begin
    logic signed [CW-1:0] p0, p1, p2, o, d;
    geo_in = '0;
    for (int n = 0; n < 3; n++) begin
      p0 = CW'($signed(in_tdata[32*n +: 32]));
      p1 = CW'($signed(in_tdata[32*(n+3) +: 32]));
      p2 = CW'($signed(in_tdata[32*(n+6) +: 32]));
      o  = CW'($signed(cfg_r[rti_pkg::CFG_OX + n]));
      d  = CW'($signed(cfg_r[rti_pkg::CFG_DX + n]));
      geo_in.e1[n] = p1 - p0;
      geo_in.e2[n] = p2 - p0;
      geo_in.s[n]  = o - p0;
      geo_in.nd[n] = -d;
      geo_in.p0[n] = in_tdata[32*n +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r[0] <= geo_in;
      for (int k = 1; k < 7; k++) geo_r[k] <= geo_r[k-1];
    end
  end

  // ------------------------------------------ S2: products of the minors
  logic signed [PW-1:0] pp_r [rti_pkg::NMINOR][2];

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] e1y, e1z, e2y, e2z, sy, sz, ndy, ndz;
    e1y = $signed(geo_r[0].e1[1]);
    e1z = $signed(geo_r[0].e1[2]);
    e2y = $signed(geo_r[0].e2[1]);
    e2z = $signed(geo_r[0].e2[2]);
    sy  = $signed(geo_r[0].s[1]);
    sz  = $signed(geo_r[0].s[2]);
    ndy = $signed(geo_r[0].nd[1]);
    ndz = $signed(geo_r[0].nd[2]);
    if (en) begin
      pp_r[rti_pkg::M_A][0]  <= e2y * ndz;
      pp_r[rti_pkg::M_A][1]  <= ndy * e2z;
      pp_r[rti_pkg::M_B][0]  <= ndy * e1z;
      pp_r[rti_pkg::M_B][1]  <= e1y * ndz;
      pp_r[rti_pkg::M_C][0]  <= e1y * e2z;
      pp_r[rti_pkg::M_C][1]  <= e2y * e1z;
      pp_r[rti_pkg::M_K1][0] <= ndy * sz;
      pp_r[rti_pkg::M_K1][1] <= sy * ndz;
      pp_r[rti_pkg::M_K2][0] <= sy * e2z;
      pp_r[rti_pkg::M_K2][1] <= e2y * sz;
      pp_r[rti_pkg::M_K3][0] <= e1y * sz;
      pp_r[rti_pkg::M_K3][1] <= sy * e1z;
    end
  end

  // ------------------------------------------------------- S3: minors
  logic signed [MW-1:0] mn_r [rti_pkg::NMINOR];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < rti_pkg::NMINOR; m++) begin
        mn_r[m] <= MW'(pp_r[m][0]) - MW'(pp_r[m][1]);
      end
    end
  end

  // ------------------------- S4: x-column times minor, minor split in two
  logic signed [PPW-1:0] pl_r [4][3];
  logic signed [PW-1:0]  ph_r [4][3];

  always_ff @(posedge clk) begin
    logic signed [CW-1:0]   xo;
    logic signed [MW-1:0]   mo;
    logic signed [LIMB:0]   lo;
    logic signed [CW-1:0]   hi;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        unique case (rti_pkg::TERM_X[r][c])
          rti_pkg::X_E1: xo = $signed(geo_r[2].e1[0]);
          rti_pkg::X_E2: xo = $signed(geo_r[2].e2[0]);
          rti_pkg::X_S:  xo = $signed(geo_r[2].s[0]);
          default:       xo = $signed(geo_r[2].nd[0]);
        endcase
        mo = mn_r[rti_pkg::TERM_M[r][c]];
        lo = $signed({1'b0, mo[LIMB-1:0]});
        hi = mo[MW-1:LIMB];
        if (en) begin
          pl_r[r][c] <= xo * lo;
          ph_r[r][c] <= xo * hi;
        end
      end
    end
  end

  // ------------------------------------- S5: join halves, apply term sign
  logic signed [DW-1:0] tp_r [4][3];

  always_ff @(posedge clk) begin
    logic signed [DW-1:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        t = (DW'(ph_r[r][c]) <<< LIMB) + DW'(pl_r[r][c]);
        if (en) tp_r[r][c] <= rti_pkg::TERM_NEG[r][c] ? -t : t;
      end
    end
  end

  // --------------------------------------------- S6: sum of three terms
  logic signed [DW-1:0] sm_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) sm_r[r] <= tp_r[r][0] + tp_r[r][1] + tp_r[r][2];
    end
  end

  // ------------------------- S7: force a positive determinant; S8..S10 carry
  logic signed [DW-1:0] nm_r [4][4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        nm_r[0][r] <= sm_r[rti_pkg::R_DET][DW-1] ? -sm_r[r] : sm_r[r];
        for (int k = 1; k < 4; k++) nm_r[k][r] <= nm_r[k-1][r];
      end
    end
  end

  // ------------------------- S8: hit decision, point numerator partials
  logic                  hit8;
  logic [3:0]            hit_r;
  logic signed [PPW-1:0] xp_r [3][3][3];

  always_comb begin
    logic signed [DW:0] bsum;
    bsum = (DW+1)'(nm_r[0][rti_pkg::R_NB]) + (DW+1)'(nm_r[0][rti_pkg::R_NG]);
    hit8 = (nm_r[0][rti_pkg::R_DET] != '0) &&
           !nm_r[0][rti_pkg::R_NB][DW-1] && !nm_r[0][rti_pkg::R_NG][DW-1] &&
           (bsum <= (DW+1)'(nm_r[0][rti_pkg::R_DET])) &&
           !nm_r[0][rti_pkg::R_NT][DW-1] && (nm_r[0][rti_pkg::R_NT] != '0);
  end

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] xo;
    logic signed [DW-1:0] yo;
    logic signed [LIMB:0] lm;
    for (int n = 0; n < 3; n++) begin
      for (int t = 0; t < 3; t++) begin
        unique case (t)
          0:       begin xo = $signed(geo_r[6].e1[n]); yo = nm_r[0][rti_pkg::R_NB]; end
          1:       begin xo = $signed(geo_r[6].e2[n]); yo = nm_r[0][rti_pkg::R_NG]; end
          default: begin
            xo = CW'($signed(geo_r[6].p0[n]));
            yo = nm_r[0][rti_pkg::R_DET];
          end
        endcase
        for (int l = 0; l < 3; l++) begin
          if (l < 2) lm = $signed({1'b0, yo[LIMB*l +: LIMB]});
          else       lm = (LIMB+1)'($signed(yo[DW-1:2*LIMB]));
          if (en) xp_r[n][t][l] <= xo * lm;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) hit_r <= {hit_r[2:0], hit8};
  end

  // ------------------------------------------- S9: join limbs of products
  logic signed [NW-1:0] pr_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        for (int t = 0; t < 3; t++) begin
          pr_r[n][t] <= (NW'(xp_r[n][t][2]) <<< (2*LIMB)) +
                        (NW'(xp_r[n][t][1]) <<< LIMB) + NW'(xp_r[n][t][0]);
        end
      end
    end
  end

  // --------------------------------------------- S10: point numerators
  logic signed [NW-1:0] num_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) num_r[n] <= pr_r[n][0] + pr_r[n][1] + pr_r[n][2];
    end
  end

  // --------------------- S11: floor fix-up for negative numerators, scale
  logic [NW-1:0]      u_r [3];
  logic [2:0]         neg_r;
  logic [DIST_NW-1:0] ud_r;
  logic [BARY_NW-1:0] ub_r, ug_r;
  logic [DW-2:0]      den_r;

  always_ff @(posedge clk) begin
    logic signed [NW:0] fix;
    for (int n = 0; n < 3; n++) begin
      fix = (NW+1)'(nm_r[3][rti_pkg::R_DET]) - (NW+1)'(1) - (NW+1)'(num_r[n]);
      if (en) begin
        neg_r[n] <= num_r[n][NW-1];
        u_r[n]   <= num_r[n][NW-1] ? fix[NW-1:0] : num_r[n];
      end
    end
    if (en) begin
      ud_r  <= {nm_r[3][rti_pkg::R_NT][DW-2:0], FRAC_BITS'(0)};
      ub_r  <= {nm_r[3][rti_pkg::R_NB][DW-2:0], rti_pkg::BARY_BITS'(0)};
      ug_r  <= {nm_r[3][rti_pkg::R_NG][DW-2:0], rti_pkg::BARY_BITS'(0)};
      den_r <= nm_r[3][rti_pkg::R_DET][DW-2:0];
    end
  end

  // --------------------------------------------------------- dividers
  logic [QB-1:0] dq, bq, gq;
  logic [QB-1:0] pq [3];
  logic          dsat, bsat, gsat;
  logic [2:0]    psat;

  rti_div #(.NUM_W(DIST_NW), .DEN_W(DW-1), .QB(QB)) u_div_dist (
    .clk(clk), .en(en), .num(ud_r), .den(den_r), .quo(dq), .sat(dsat)
  );
  rti_div #(.NUM_W(BARY_NW), .DEN_W(DW-1), .QB(QB)) u_div_beta (
    .clk(clk), .en(en), .num(ub_r), .den(den_r), .quo(bq), .sat(bsat)
  );
  rti_div #(.NUM_W(BARY_NW), .DEN_W(DW-1), .QB(QB)) u_div_gamma (
    .clk(clk), .en(en), .num(ug_r), .den(den_r), .quo(gq), .sat(gsat)
  );
  for (genvar n = 0; n < 3; n++) begin : g_pt
    rti_div #(.NUM_W(NW), .DEN_W(DW-1), .QB(QB)) u_div_pt (
      .clk(clk), .en(en), .num(u_r[n]), .den(den_r), .quo(pq[n]), .sat(psat[n])
    );
  end

  // hold the per-request flags alongside the dividers
  rti_pkg::rti_side_t side_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QB; j++) side_r[j].v <= 1'b0;
    end else if (en) begin
      side_r[0].v <= vld_r[10];
      for (int j = 1; j <= QB; j++) side_r[j].v <= side_r[j-1].v;
    end
    if (en) begin
      side_r[0].hit <= hit_r[3];
      side_r[0].neg <= neg_r;
      for (int j = 1; j <= QB; j++) begin
        side_r[j].hit <= side_r[j-1].hit;
        side_r[j].neg <= side_r[j-1].neg;
      end
    end
  end

  // ------------------------------------------------- saturate and pack
  logic [rti_pkg::OUT_W-1:0] res_data;
  logic                      res_hit;
  logic                      res_v;

  always_comb begin
    logic [30:0]  dist_v;
    logic [31:0]  pt [3];
    logic [16:0]  beta, gamma;
    rti_pkg::rti_side_t sd;
    sd     = side_r[QB];
    dist_v = (dsat || dq[QB-1]) ? rti_pkg::DIST_MAX : dq[30:0];
    for (int n = 0; n < 3; n++) begin
      if (!sd.neg[n]) pt[n] = (psat[n] || pq[n][31]) ? rti_pkg::PT_MAX : pq[n];
      else pt[n] = (psat[n] || (pq[n][31] && (pq[n][30:0] != '0))) ? rti_pkg::PT_MIN : -pq[n];
    end
    beta  = (bsat || (bq > QB'(rti_pkg::BARY_ONE))) ? rti_pkg::BARY_ONE : bq[16:0];
    gamma = (gsat || (gq > QB'(rti_pkg::BARY_ONE))) ? rti_pkg::BARY_ONE : gq[16:0];
    res_v   = sd.v;
    res_hit = sd.hit;
    res_data = sd.hit ? {7'b0, gamma, beta, pt[2], pt[1], pt[0], dist_v} : '0;
  end

  // ---------------------------------------- output register and skid
  logic [rti_pkg::OUT_W-1:0] out_data_r, skid_data_r;
  logic                      out_hit_r, skid_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= res_v;
      end
    end else if (res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_data_r <= skid_data_r;
        out_hit_r  <= skid_hit_r;
      end else begin
        out_data_r <= res_data;
        out_hit_r  <= res_hit;
      end
    end else if (en) begin
      skid_data_r <= res_data;
      skid_hit_r  <= res_hit;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

endmodule

// ===== src/rti_chk.sv =====
`timescale 1ns / 1ps

module rti_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [rti_pkg::OUT_W-1:0] out_tdata,
  input logic [0:0]                out_tuser
);

  // results are dropped by reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("miss carries non-zero fields");

  a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      ({1'b0, out_tdata[143:127]} + {1'b0, out_tdata[160:144]}) <= 18'h10000)
    else $error("barycentric weights exceed one");

endmodule

bind ray_triangle_intersection rti_chk u_rti_chk (
  .clk(clk),
  .rst_n(rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

// ===== bench/ray_triangle_intersection_tb.sv =====
`timescale 1ns / 1ps

module ray_triangle_intersection_tb;

  typedef logic signed [255:0] wide_t;
  // one triangle: word 0 is v0_x, up to word 8 for v2_z
  typedef logic [8:0][31:0] tri_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [16:0] beta;
    logic [16:0] gamma;
  } hit_res_t;

  localparam int LIMIT = 600000;
  localparam int DRAIN = 60;  // comfortably above the pipeline latency

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [rti_pkg::IN_W-1:0]     in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [rti_pkg::OUT_W-1:0]    out_tdata;
  logic [0:0]                   out_tuser;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [rti_pkg::ADDR_W-1:0]   cfg_paddr;
  logic [rti_pkg::DATA_W-1:0]   cfg_pwdata;
  logic [rti_pkg::DATA_W-1:0]   cfg_prdata;
  logic                         cfg_pready;

  ray_triangle_intersection dut (.*);

  // shadow of the ray registers, kept in step with every write
  logic [31:0] ray_reg [rti_pkg::NCFG];

  tri_t     tri_feed [$];
  hit_res_t hits_due [$];
  int       mismatches;
  int       cycles;
  bit       calm;  // suppress idling on both sides

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // ---------------------------------------------------------------------
  // Predictor: solve the 3x3 system exactly in wide integers
  // ---------------------------------------------------------------------
  function automatic wide_t sx(input logic signed [31:0] v);
    return v;
  endfunction

  // floor division, den positive
  function automatic wide_t floor_div(input wide_t num, input wide_t den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic wide_t clamp(input wide_t x, input wide_t lo, input wide_t hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic hit_res_t trace_triangle(input tri_t t);
    wide_t p0 [3];
    wide_t e1 [3];
    wide_t e2 [3];
    wide_t s [3];
    wide_t nd [3];
    wide_t ma, mb, mc, det, nb, ng, nt, num;
    hit_res_t r;
    r = '0;
    for (int n = 0; n < 3; n++) begin
      p0[n] = sx(t[n]);
      e1[n] = sx(t[3+n]) - p0[n];
      e2[n] = sx(t[6+n]) - p0[n];
      s[n]  = sx(ray_reg[n]) - p0[n];
      nd[n] = -sx(ray_reg[3+n]);
    end
    ma  = e2[1]*nd[2] - nd[1]*e2[2];
    mb  = nd[1]*e1[2] - e1[1]*nd[2];
    mc  = e1[1]*e2[2] - e2[1]*e1[2];
    det = e1[0]*ma + e2[0]*mb + nd[0]*mc;
    // degenerate triangle or ray parallel to its plane
    if (det == 0) return r;
    nb = s[0]*ma + e2[0]*(nd[1]*s[2] - s[1]*nd[2]) + nd[0]*(s[1]*e2[2] - e2[1]*s[2]);
    ng = e1[0]*(s[1]*nd[2] - nd[1]*s[2]) + s[0]*mb + nd[0]*(e1[1]*s[2] - s[1]*e1[2]);
    nt = e1[0]*(e2[1]*s[2] - s[1]*e2[2]) + e2[0]*(s[1]*e1[2] - e1[1]*s[2]) + s[0]*mc;
    if (det < 0) begin
      det = -det; nb = -nb; ng = -ng; nt = -nt;
    end
    if (nb < 0 || ng < 0 || det < nb + ng || nt <= 0) return r;
    r.hit = 1'b1;
    r.distance = 31'(clamp(floor_div(nt * 65536, det), 0, 64'sh7FFF_FFFF));
    num = e1[0]*nb + e2[0]*ng + p0[0]*det;
    r.px = 32'(clamp(floor_div(num, det), -64'sh8000_0000, 64'sh7FFF_FFFF));
    num = e1[1]*nb + e2[1]*ng + p0[1]*det;
    r.py = 32'(clamp(floor_div(num, det), -64'sh8000_0000, 64'sh7FFF_FFFF));
    num = e1[2]*nb + e2[2]*ng + p0[2]*det;
    r.pz = 32'(clamp(floor_div(num, det), -64'sh8000_0000, 64'sh7FFF_FFFF));
    r.beta  = 17'(clamp(floor_div(nb * 65536, det), 0, 65536));
    r.gamma = 17'(clamp(floor_div(ng * 65536, det), 0, 65536));
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: advance on handshake, idle at random
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (tri_feed.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= tri_feed.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls at random unless calm
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(99) >= 30);
  end

  // predict every accepted request
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) hits_due.push_back(trace_triangle(in_tdata));
  end

  // check every result against the oldest prediction
  always @(posedge clk) begin
    hit_res_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit      = out_tuser[0];
      got.distance = out_tdata[30:0];
      got.px       = out_tdata[62:31];
      got.py       = out_tdata[94:63];
      got.pz       = out_tdata[126:95];
      got.beta     = out_tdata[143:127];
      got.gamma    = out_tdata[160:144];
      if (hits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = hits_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic write_reg(input int idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= rti_pkg::ADDR_W'(4 * idx);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    ray_reg[idx] = val;
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
    write_reg(rti_pkg::CFG_OX, ox);
    write_reg(rti_pkg::CFG_OY, oy);
    write_reg(rti_pkg::CFG_OZ, oz);
    write_reg(rti_pkg::CFG_DX, dx);
    write_reg(rti_pkg::CFG_DY, dy);
    write_reg(rti_pkg::CFG_DZ, dz);
  endtask

  // hold until every request has gone through and the pipeline is empty
  task automatic drain();
    do @(posedge clk);
    while (tri_feed.size() > 0 || in_tvalid || hits_due.size() > 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [31:0] small_val(input int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  // a point on the ray at a random distance, wrapped to 32 bits
  function automatic logic [31:0] on_ray(input int n, input longint k);
    return 32'(longint'($signed(ray_reg[n])) + ((k * longint'($signed(ray_reg[3+n]))) >>> 16));
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    logic [31:0] h [3];
    logic [31:0] a, b;
    longint k;
    int kind;
    kind = $urandom_range(99);
    k = longint'($urandom_range(32'h0008_0000)) - 32'h0000_8000;
    for (int n = 0; n < 3; n++) h[n] = on_ray(n, k);
    for (int n = 0; n < 3; n++) begin
      a = small_val(1 << ($urandom_range(20) + 1));
      b = small_val(1 << ($urandom_range(20) + 1));
      if (kind < 45) begin
        // well-formed: the ray point is the centroid
        t[n] = h[n] + a; t[3+n] = h[n] + b; t[6+n] = h[n] - a - b;
      end else if (kind < 55) begin
        // ray through a vertex or along an edge
        t[n] = h[n]; t[3+n] = h[n] + a; t[6+n] = h[n] + ((kind & 1) ? b : -a);
      end else if (kind < 65) begin
        // degenerate: coincident or collinear vertices
        t[n] = h[n] + a; t[3+n] = h[n] + b; t[6+n] = h[n] + b + b - a;
      end else if (kind < 82) begin
        t[n] = small_val(1 << 22); t[3+n] = small_val(1 << 22); t[6+n] = small_val(1 << 22);
      end else begin
        t[n] = $urandom; t[3+n] = $urandom; t[6+n] = $urandom;
      end
    end
    return t;
  endfunction

  task automatic run_random(input int count);
    repeat (count) tri_feed.push_back(random_tri());
  endtask

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MONE = 32'hFFFF_0000;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mismatches  = 0;
    cycles      = 0;
    calm        = 1'b0;
    for (int n = 0; n < rti_pkg::NCFG; n++) ray_reg[n] = '0;
    ray_reg[rti_pkg::CFG_DZ] = ONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed set on the reset ray: origin zero, direction +z
    // all zero, degenerate
    tri_feed.push_back('0);
    // plain hit in front at z = 5
    tri_feed.push_back({32'h5_0000, 32'h2_0000, MONE, 32'h5_0000, MONE, 32'h2_0000,
                        32'h5_0000, MONE, MONE});
    // same triangle behind the origin
    tri_feed.push_back({32'hFFFB_0000, 32'h2_0000, MONE, 32'hFFFB_0000, MONE,
                        32'h2_0000, 32'hFFFB_0000, MONE, MONE});
    // plane through the origin: zero distance is a miss
    tri_feed.push_back({32'h0, 32'h2_0000, MONE, 32'h0, MONE, 32'h2_0000, 32'h0, MONE, MONE});
    // ray through vertex v0 (beta = gamma = 0)
    tri_feed.push_back({32'h3_0000, 32'h0, ONE, 32'h3_0000, ONE, 32'h0, 32'h3_0000, 32'h0, 32'h0});
    // ray through v1 (beta one)
    tri_feed.push_back({32'h3_0000, ONE, 32'h0, 32'h3_0000, 32'h0, 32'h0, 32'h3_0000, MONE, MONE});
    // ray on edge v1-v2 (beta + gamma one)
    tri_feed.push_back({32'h3_0000, ONE, MONE, 32'h3_0000, MONE, ONE, 32'h3_0000, ONE, ONE});
    // the same edge with v1_x and v2_x one step nearer zero: still on it
    tri_feed.push_back({32'h3_0000, ONE, 32'hFFFF_0001, 32'h3_0000, MONE, 32'h0000_FFFF,
                        32'h3_0000, ONE, ONE});
    // tiny distance: plane at one step
    tri_feed.push_back({32'h1, 32'h2_0000, MONE, 32'h1, MONE, 32'h2_0000, 32'h1, MONE, MONE});
    // ray parallel to the plane
    tri_feed.push_back({ONE, 32'h0, 32'h0, 32'h0, ONE, 32'h0, 32'h0, 32'h0, 32'h0});
    // extremes of every field
    tri_feed.push_back({9{SMAX}});
    tri_feed.push_back({9{SMIN}});
    tri_feed.push_back({SMAX, SMIN, SMIN, SMIN, SMAX, SMIN, SMIN, SMIN, SMAX});
    tri_feed.push_back({SMAX, SMIN, SMAX, SMAX, SMAX, SMIN, SMIN, SMAX, SMIN});
    tri_feed.push_back({SMAX, SMAX, SMIN, SMAX, SMIN, SMAX, SMAX, SMIN, SMIN});
    tri_feed.push_back({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
                        32'h0, 32'h0, 32'hFFFF_FFFF});
    // huge triangle far away: point near saturation
    tri_feed.push_back({32'h7000_0000, 32'h7000_0000, SMIN, 32'h7000_0000, SMIN,
                        32'h7000_0000, 32'h7000_0000, SMIN, SMIN});
    run_random(170);
    drain();

    // small ray, long stretch with no idling at all
    calm = 1'b1;
    set_ray(small_val(1 << 20), small_val(1 << 20), small_val(1 << 20),
            small_val(1 << 18), small_val(1 << 18), small_val(1 << 18));
    run_random(190);
    drain();
    calm = 1'b0;

    // tiny direction: far hits saturate the distance
    set_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1);
    run_random(140);
    drain();

    // zero direction: every determinant is zero
    set_ray($urandom, $urandom, $urandom, 32'h0, 32'h0, 32'h0);
    run_random(60);
    drain();

    // extreme origin and direction
    set_ray(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX);
    run_random(190);
    drain();

    set_ray(SMAX, SMIN, SMAX, MONE, ONE, MONE);
    run_random(190);
    drain();

    // full-range random rays
    repeat (2) begin
      set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(100);
      drain();
    end

    // moderate rays, mixed idling
    set_ray(small_val(1 << 24), small_val(1 << 24), small_val(1 << 24),
            small_val(1 << 17), small_val(1 << 17), small_val(1 << 17));
    run_random(190);
    drain();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rti_pkg.sv
src/rti_div.sv
src/ray_triangle_intersection.sv
src/rti_chk.sv
bench/ray_triangle_intersection_tb.sv
